### sv/bfp_pkg.sv
// Shared types and constants for the binomial factor product block.
// Depends on nothing; front, back and top use it by scoped names.
package bfp_pkg;

   localparam int MAX_FACTORS_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int PIDX_W          = 6;
   localparam int QUEUE_DEPTH     = 2;

   // How the back end treats one factor.
   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_UPDATE = 2'd1,
      KIND_DROP   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     last;
      logic     dropped;
   } bfp_ctrl_type;

endpackage

### sv/bfp_req_if.sv
// Input channel: one linear factor per transaction.
// Depends on nothing.
interface bfp_req_if #(
   parameter int VAL_W = 17
);
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] p_coef;
   logic [VAL_W-1:0] q_coef;
   logic             last_factor;

   modport source (output valid, output p_coef, output q_coef, output last_factor,
                   input ready);
   modport sink (input valid, input p_coef, input q_coef, input last_factor,
                 output ready);
endinterface

### sv/bfp_rsp_if.sv
// Result channel: one product coefficient per transaction.
// Depends on nothing.
interface bfp_rsp_if #(
   parameter int VAL_W  = 17,
   parameter int PIDX_W = 6
);
   logic              valid;
   logic              ready;
   logic [VAL_W-1:0]  coefficient;
   logic [PIDX_W-1:0] power_index;
   logic              last_coef;
   logic              dropped_factors;

   modport source (output valid, output coefficient, output power_index,
                   output last_coef, output dropped_factors, input ready);
   modport sink (input valid, input coefficient, input power_index,
                 input last_coef, input dropped_factors, output ready);
endinterface

### sv/bfp_csr_if.sv
// Configuration write channel for the complement mode register.
// Depends on nothing.
interface bfp_csr_if;
   logic valid;
   logic ready;
   logic complement_mode;

   modport source (output valid, output complement_mode, input ready);
   modport sink (input valid, input complement_mode, output ready);
endinterface

### sv/bfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bfp_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 33
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/bfp_queue.sv
// Short FIFO between the front end and the back end.
// Depends on nothing.
module bfp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign push       = push_valid && push_ready;
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/bfp_front.sv
// Front end: takes factor transactions, saturates them, sets q to 1 - p in complement
// mode, classifies them by the running count. Depends on bfp_pkg, bfp_req_if, bfp_csr_if.
module bfp_front #(
   parameter int MAX_FACTORS = bfp_pkg::MAX_FACTORS_DEF,
   parameter int FRAC_BITS   = bfp_pkg::FRAC_BITS_DEF,
   localparam int VAL_W      = FRAC_BITS + 1,
   localparam int CNT_W      = $clog2(MAX_FACTORS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   bfp_req_if.sink                req,
   bfp_csr_if.sink                csr,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic [VAL_W-1:0]       push_p,
   output logic [VAL_W-1:0]       push_q,
   output logic [CNT_W-1:0]       push_count,
   output bfp_pkg::bfp_ctrl_type  push_ctrl
);

   localparam logic [VAL_W-1:0] UNIT_VAL = {1'b1, {FRAC_BITS{1'b0}}};

   logic             mode_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [VAL_W-1:0] p_sat, q_sat;
   logic             accept;

   assign csr.ready  = 1'b1;
   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign accept     = req.valid && push_ready;

   assign p_sat = (req.p_coef > UNIT_VAL) ? UNIT_VAL : req.p_coef;
   assign q_sat = (req.q_coef > UNIT_VAL) ? UNIT_VAL : req.q_coef;

   always_comb begin
      push_p     = p_sat;
      push_q     = mode_ff ? (UNIT_VAL - p_sat) : q_sat;
      push_count = count_ff;
      priority if (count_ff == '0) begin
         push_ctrl.kind = bfp_pkg::KIND_LOAD;
      end else if (count_ff < CNT_W'(MAX_FACTORS)) begin
         push_ctrl.kind = bfp_pkg::KIND_UPDATE;
      end else begin
         push_ctrl.kind = bfp_pkg::KIND_DROP;
      end
      push_ctrl.last    = req.last_factor;
      push_ctrl.dropped = ovf_ff || (push_ctrl.kind == bfp_pkg::KIND_DROP);
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req.last_factor) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            ovf_in = push_ctrl.dropped;
            if (push_ctrl.kind != bfp_pkg::KIND_DROP) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         if (csr.valid) begin
            mode_ff <= csr.complement_mode;
         end
      end
   end

endmodule

### sv/bfp_back.sv
// Back end: sweeps the coefficient memory through a multiply-accumulate pipeline
// and streams the finished polynomial. Depends on bfp_pkg, bfp_ram, bfp_rsp_if.
module bfp_back #(
   parameter int MAX_FACTORS = bfp_pkg::MAX_FACTORS_DEF,
   parameter int FRAC_BITS   = bfp_pkg::FRAC_BITS_DEF,
   localparam int VAL_W      = FRAC_BITS + 1,
   localparam int CNT_W      = $clog2(MAX_FACTORS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  logic [VAL_W-1:0]       hd_p,
   input  logic [VAL_W-1:0]       hd_q,
   input  logic [CNT_W-1:0]       hd_count,
   input  bfp_pkg::bfp_ctrl_type  hd_ctrl,
   bfp_rsp_if.source              rsp
);

   localparam int PROD_W = 2 * VAL_W;
   localparam int SUM_W  = VAL_W + 1;
   localparam logic [VAL_W-1:0]  UNIT_VAL = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PROD_W-1:0] HALF_VAL =
      {{(PROD_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_SWEEP     = 6'b000010,
      ST_DRAIN     = 6'b000100,
      ST_EMIT_RD   = 6'b001000,
      ST_EMIT_WAIT = 6'b010000,
      ST_EMIT_HOLD = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [VAL_W-1:0]  prev_ff, prev_in;
   logic              rd_valid_ff;
   logic [CNT_W-1:0]  rd_idx_ff;
   logic              mul_valid_ff;
   logic [CNT_W-1:0]  mul_idx_ff;
   logic [PROD_W-1:0] prod_q_ff, prod_p_ff;
   logic              out_valid_ff, out_valid_in;
   logic [VAL_W-1:0]  out_coef_ff, out_coef_in;
   logic [CNT_W-1:0]  out_idx_ff, out_idx_in;
   logic              out_last_ff, out_last_in;
   logic              out_drop_ff, out_drop_in;

   logic              rd_en;
   logic [CNT_W-1:0]  rd_addr;
   logic [VAL_W-1:0]  rd_data;
   logic [VAL_W-1:0]  wr_data;
   logic [VAL_W-1:0]  cur_val;
   logic [PROD_W-1:0] rnd_q, rnd_p;
   logic [SUM_W-1:0]  sum;
   logic [CNT_W-1:0]  sweep_top, final_top;

   bfp_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_FACTORS + 1)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (mul_valid_ff),
      .wr_addr (mul_idx_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sweep_top = hd_count + CNT_W'(1);
   assign final_top = (hd_ctrl.kind == bfp_pkg::KIND_DROP) ? hd_count : sweep_top;

   // The first factor of a run is applied to the constant polynomial 1, so the
   // seed entry reads as one and every entry above the old top reads as zero.
   always_comb begin
      if (hd_ctrl.kind == bfp_pkg::KIND_LOAD) begin
         cur_val = (rd_idx_ff == '0) ? UNIT_VAL : '0;
      end else begin
         cur_val = (rd_idx_ff <= hd_count) ? rd_data : '0;
      end
   end

   // Round each product to nearest, add, and saturate at one.
   always_comb begin
      rnd_q   = prod_q_ff + HALF_VAL;
      rnd_p   = prod_p_ff + HALF_VAL;
      sum     = SUM_W'(rnd_q >> FRAC_BITS) + SUM_W'(rnd_p >> FRAC_BITS);
      wr_data = (sum > SUM_W'(UNIT_VAL)) ? UNIT_VAL : sum[VAL_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      prev_in      = rd_valid_ff ? cur_val : prev_ff;
      out_valid_in = out_valid_ff;
      out_coef_in  = out_coef_ff;
      out_idx_in   = out_idx_ff;
      out_last_in  = out_last_ff;
      out_drop_in  = out_drop_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (hd_ctrl.kind == bfp_pkg::KIND_DROP) begin
                  if (hd_ctrl.last) begin
                     state_in = ST_EMIT_RD;
                     idx_in   = '0;
                  end else begin
                     q_pop = 1'b1;
                  end
               end else begin
                  state_in = ST_SWEEP;
                  idx_in   = '0;
                  prev_in  = '0;
               end
            end
         end
         ST_SWEEP: begin
            rd_en = 1'b1;
            if (idx_ff == sweep_top) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !mul_valid_ff) begin
               if (hd_ctrl.last) begin
                  state_in = ST_EMIT_RD;
                  idx_in   = '0;
               end else begin
                  q_pop    = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT_RD: begin
            rd_en    = 1'b1;
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            out_valid_in = 1'b1;
            out_coef_in  = rd_data;
            out_idx_in   = idx_ff;
            out_last_in  = (idx_ff == final_top);
            out_drop_in  = hd_ctrl.dropped;
            state_in     = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (rsp.ready) begin
               out_valid_in = 1'b0;
               if (out_last_ff) begin
                  q_pop    = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  rd_en    = 1'b1;
                  rd_addr  = idx_ff + CNT_W'(1);
                  state_in = ST_EMIT_WAIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= (state_ff == ST_SWEEP);
         mul_valid_ff <= rd_valid_ff;
         out_valid_ff <= out_valid_in;
      end
      idx_ff      <= idx_in;
      prev_ff     <= prev_in;
      rd_idx_ff   <= idx_ff;
      mul_idx_ff  <= rd_idx_ff;
      prod_q_ff   <= PROD_W'(cur_val) * PROD_W'(hd_q);
      prod_p_ff   <= PROD_W'(prev_ff) * PROD_W'(hd_p);
      out_coef_ff <= out_coef_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
      out_drop_ff <= out_drop_in;
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.coefficient     = out_coef_ff;
   assign rsp.power_index     = bfp_pkg::PIDX_W'(out_idx_ff);
   assign rsp.last_coef       = out_last_ff;
   assign rsp.dropped_factors = out_drop_ff;

   a_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      mul_valid_ff |-> (state_ff == ST_SWEEP || state_ff == ST_DRAIN))
      else $error("coefficient write outside the update sweep");

   a_out_only_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (state_ff == ST_EMIT_HOLD))
      else $error("result presented outside the emit hold state");

   a_read_feeds_mac: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |=> mul_valid_ff)
      else $error("sweep read did not reach the write stage");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

endmodule

### sv/binomial_factor_product.sv
// Multiplies linear factors (q + p*z) into one polynomial with Q1.FRAC_BITS
// coefficients and streams the result on the factor marked last. A factor waits in
// a two-entry queue while the back end sweeps the coefficient memory one entry a
// cycle through a rounding multiply-accumulate pipeline; the back end takes the next
// factor only once that sweep has drained. A factor beyond MAX_FACTORS is discarded
// and flagged. The n+1 results of a run that keeps n factors leave one at a time:
// each is read from the registered memory into the output register after the sink
// has taken the one before it.
module binomial_factor_product #(
   parameter int MAX_FACTORS = bfp_pkg::MAX_FACTORS_DEF,
   parameter int FRAC_BITS   = bfp_pkg::FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bfp_req_if.sink    req,
   bfp_rsp_if.source  rsp,
   bfp_csr_if.sink    csr
);

   localparam int VAL_W  = FRAC_BITS + 1;
   localparam int CNT_W  = $clog2(MAX_FACTORS + 1);
   localparam int CTRL_W = $bits(bfp_pkg::bfp_ctrl_type);
   localparam int QW     = CTRL_W + CNT_W + 2 * VAL_W;

   logic                  push_valid, push_ready;
   logic [VAL_W-1:0]      push_p, push_q;
   logic [CNT_W-1:0]      push_count;
   bfp_pkg::bfp_ctrl_type push_ctrl;
   logic [QW-1:0]         push_data, head_data;
   logic                  head_valid, q_pop;
   logic [VAL_W-1:0]      hd_p, hd_q;
   logic [CNT_W-1:0]      hd_count;
   bfp_pkg::bfp_ctrl_type hd_ctrl;

   bfp_front #(
      .MAX_FACTORS (MAX_FACTORS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr        (csr),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_p     (push_p),
      .push_q     (push_q),
      .push_count (push_count),
      .push_ctrl  (push_ctrl)
   );

   assign push_data = {push_ctrl, push_count, push_p, push_q};

   bfp_queue #(
      .WIDTH (QW),
      .DEPTH (bfp_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign {hd_ctrl, hd_count, hd_p, hd_q} = head_data;

   bfp_back #(
      .MAX_FACTORS (MAX_FACTORS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (head_valid),
      .q_pop    (q_pop),
      .hd_p     (hd_p),
      .hd_q     (hd_q),
      .hd_count (hd_count),
      .hd_ctrl  (hd_ctrl),
      .rsp      (rsp)
   );

endmodule
